// File: rtl/fmpf_pkg.sv
// Shared types, codes and helpers for the first-match packet filter.
// Depends on nothing; every other file of the filter but fmpf_ram imports it.
package fmpf_pkg;

   localparam int ADDR_W   = 32;
   localparam int TAG_W    = 16;
   localparam int PORT_W   = 16;
   localparam int PREFIX_W = 6;
   localparam int ACTION_W = 2;
   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 6;
   localparam int ACTIVE_W = 7;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [MODE_W-1:0] MODE_LOAD     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_APPEND   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd2;

   localparam logic [ACTION_W-1:0] VERDICT_ACCEPT = 2'd0;
   localparam logic [ACTION_W-1:0] VERDICT_REJECT = 2'd1;
   localparam logic [ACTION_W-1:0] VERDICT_DROP   = 2'd2;

   localparam logic [PREFIX_W-1:0] PREFIX_MAX = 6'd32;

   localparam logic CSR_ACTIVE_RULES = 1'b0;

   typedef struct packed {
      logic                dir;
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   network;
      logic [PREFIX_W-1:0] prefix;
      logic                any_address;
      logic                any_port;
      logic                needs_est;
      logic [TAG_W-1:0]    tag;
   } rule_hdr_type;

   localparam int HDR_W = $bits(rule_hdr_type);

   typedef struct packed {
      logic hdr_hit;
      logic any_port;
      logic port_hit;
   } match_type;

   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] plen);
      logic [ADDR_W-1:0] ones;
      ones = {ADDR_W{1'b1}};
      if (plen >= PREFIX_MAX) begin
         return ones;
      end
      return ~(ones >> plen);
   endfunction

endpackage

// File: rtl/fmpf_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module fmpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fmpf_match.sv
// Shared compare unit: checks one rule header and one stored port against a packet.
// Depends on fmpf_pkg.
module fmpf_match (
   input  fmpf_pkg::rule_hdr_type            hdr,
   input  logic                              pkt_dir,
   input  logic [fmpf_pkg::ADDR_W-1:0]       pkt_address,
   input  logic                              pkt_established,
   input  logic [fmpf_pkg::PORT_W-1:0]       pkt_port,
   input  logic [fmpf_pkg::PORT_W-1:0]       stored_port,
   output fmpf_pkg::match_type               result
);
   import fmpf_pkg::*;

   logic [ADDR_W-1:0] mask;
   logic              addr_ok;
   logic              est_ok;

   always_comb begin
      mask            = prefix_mask(hdr.prefix);
      addr_ok         = hdr.any_address || ((pkt_address & mask) == (hdr.network & mask));
      est_ok          = !hdr.needs_est || pkt_established;
      result.hdr_hit  = (hdr.dir == pkt_dir) && addr_ok && est_ok;
      result.any_port = hdr.any_port;
      result.port_hit = (stored_port == pkt_port);
   end

endmodule

// File: rtl/first_match_packet_filter.sv
// Top level of the first-match packet filter: sequencer, rule and port stores, CSR.
// Depends on fmpf_pkg, fmpf_ram and fmpf_match.
//
//  Channel  Direction  Handshake                 Payload
//  req      in         req_valid / req_stall     mode, rule, packet fields
//  rsp      out        rsp_valid / rsp_stall     verdict, matched, tag, status
//  csr      in/out     APB psel/penable/pready   active_rules at offset 0
//
// A header load passes through EMIT to the result register; a port append passes
// through APP_RD, APP_WR and EMIT. A classify visits CL_HDR and CL_EVL per rule
// searched, staying in CL_EVL while the single compare unit checks stored ports
// in turn, and ends in EMIT. After reset the rule store is swept before req is taken.
// req_stall is high while an item is in work or its result cannot be registered.
module first_match_packet_filter #(
   parameter int RULE_SLOTS     = 64,
   parameter int PORTS_PER_RULE = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fmpf_pkg::MODE_W-1:0]         req_mode,
   input  logic [fmpf_pkg::INDEX_W-1:0]        req_rule_index,
   input  logic                                req_direction,
   input  logic [fmpf_pkg::ACTION_W-1:0]       req_action_code,
   input  logic [fmpf_pkg::ADDR_W-1:0]         req_address,
   input  logic [fmpf_pkg::PREFIX_W-1:0]       req_prefix_len,
   input  logic                                req_any_address,
   input  logic                                req_any_port,
   input  logic                                req_needs_established,
   input  logic [fmpf_pkg::TAG_W-1:0]          req_rule_tag,
   input  logic [fmpf_pkg::PORT_W-1:0]         req_port_number,
   input  logic                                req_established,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fmpf_pkg::ACTION_W-1:0]       rsp_verdict,
   output logic                                rsp_matched,
   output logic [fmpf_pkg::TAG_W-1:0]          rsp_matched_tag,
   output logic                                rsp_status,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fmpf_pkg::CSR_AW-1:0]         csr_paddr,
   input  logic [fmpf_pkg::CSR_DW-1:0]         csr_pwdata,
   output logic [fmpf_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                                csr_pready
);
   import fmpf_pkg::*;

   localparam int RW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
   localparam int PW = (RULE_SLOTS * PORTS_PER_RULE > 1) ?
                       $clog2(RULE_SLOTS * PORTS_PER_RULE) : 1;
   localparam int FW = $clog2(PORTS_PER_RULE + 1);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_APP_RD = 3'd2;
   localparam logic [2:0] ST_APP_WR = 3'd3;
   localparam logic [2:0] ST_CL_HDR = 3'd4;
   localparam logic [2:0] ST_CL_EVL = 3'd5;
   localparam logic [2:0] ST_EMIT   = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic [RW-1:0]       clr_ff, clr_in;
   logic [RW-1:0]       r_ff, r_in;
   logic [FW-1:0]       j_ff, j_in;
   logic [PW-1:0]       base_ff, base_in;
   logic [ACTIVE_W-1:0] lim_ff, lim_in;
   logic [ACTIVE_W-1:0] active_ff, active_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic                dir_ff, dir_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [PORT_W-1:0]   port_ff, port_in;
   logic                est_ff, est_in;
   logic [ACTION_W-1:0] res_verdict_ff, res_verdict_in;
   logic                res_matched_ff, res_matched_in;
   logic [TAG_W-1:0]    res_tag_ff, res_tag_in;
   logic                res_status_ff, res_status_in;
   logic [ACTION_W-1:0] rsp_verdict_ff, rsp_verdict_in;
   logic                rsp_matched_ff, rsp_matched_in;
   logic [TAG_W-1:0]    rsp_tag_ff, rsp_tag_in;
   logic                rsp_status_ff, rsp_status_in;

   logic                accept;
   logic                req_idx_ok;
   logic                idx_ok;
   logic                out_free;
   logic                last_rule;
   logic                csr_write;
   rule_hdr_type        new_hdr;
   rule_hdr_type        hdr_q;
   logic [FW-1:0]       fill_q;
   logic [HDR_W+FW-1:0] hdr_rd_data;
   logic                hdr_we;
   logic [RW-1:0]       hdr_wa;
   logic [HDR_W+FW-1:0] hdr_wd;
   logic [RW-1:0]       hdr_ra;
   logic                port_we;
   logic [PW-1:0]       port_wa;
   logic [PW-1:0]       port_ra;
   logic [PORT_W-1:0]   port_q;
   logic [PW-1:0]       append_addr;
   match_type           mres;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_idx_ok = int'(req_rule_index) < RULE_SLOTS;
   assign idx_ok     = int'(idx_ff) < RULE_SLOTS;
   assign last_rule  = (int'(r_ff) + 1) >= int'(lim_ff);
   assign {fill_q, hdr_q} = hdr_rd_data;
   assign append_addr = PW'(PW'(RW'(idx_ff)) * PW'(PORTS_PER_RULE)) + PW'(fill_q);

   always_comb begin
      new_hdr.dir         = req_direction;
      new_hdr.action      = (req_action_code > VERDICT_DROP) ? VERDICT_DROP : req_action_code;
      new_hdr.network     = req_address;
      new_hdr.prefix      = (req_prefix_len > PREFIX_MAX) ? PREFIX_MAX : req_prefix_len;
      new_hdr.any_address = req_any_address;
      new_hdr.any_port    = req_any_port;
      new_hdr.needs_est   = req_needs_established;
      new_hdr.tag         = req_rule_tag;
   end

   // Configuration port.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_ACTIVE_RULES) ? CSR_DW'(active_ff) : '0;

   always_comb begin
      active_in = active_ff;
      if (csr_write && (csr_paddr[2] == CSR_ACTIVE_RULES)) begin
         active_in = csr_pwdata[ACTIVE_W-1:0];
      end
   end

   // Store ports.
   always_comb begin
      hdr_we  = 1'b0;
      hdr_wa  = RW'(idx_ff);
      hdr_wd  = {FW'(fill_q + FW'(1)), hdr_q};
      port_we = 1'b0;
      if (state_ff == ST_CLEAR) begin
         hdr_we = 1'b1;
         hdr_wa = clr_ff;
         hdr_wd = '0;
      end else if (accept && (req_mode == MODE_LOAD) && req_idx_ok) begin
         hdr_we = 1'b1;
         hdr_wa = RW'(req_rule_index);
         hdr_wd = {FW'(0), new_hdr};
      end else if ((state_ff == ST_APP_WR) && (fill_q < FW'(PORTS_PER_RULE))) begin
         hdr_we  = 1'b1;
         port_we = 1'b1;
      end
      port_wa = append_addr;
      hdr_ra  = ((state_ff == ST_CL_HDR) || (state_ff == ST_CL_EVL)) ? r_ff : RW'(idx_ff);
   end

   assign port_ra = base_ff + PW'(j_in);

   fmpf_ram #(
      .WIDTH (HDR_W + FW),
      .DEPTH (RULE_SLOTS),
      .AW    (RW)
   ) u_rule_ram (
      .clock   (clock),
      .wr_en   (hdr_we),
      .wr_addr (hdr_wa),
      .wr_data (hdr_wd),
      .rd_addr (hdr_ra),
      .rd_data (hdr_rd_data)
   );

   fmpf_ram #(
      .WIDTH (PORT_W),
      .DEPTH (RULE_SLOTS * PORTS_PER_RULE),
      .AW    (PW)
   ) u_port_ram (
      .clock   (clock),
      .wr_en   (port_we),
      .wr_addr (port_wa),
      .wr_data (port_ff),
      .rd_addr (port_ra),
      .rd_data (port_q)
   );

   fmpf_match u_match (
      .hdr             (hdr_q),
      .pkt_dir         (dir_ff),
      .pkt_address     (addr_ff),
      .pkt_established (est_ff),
      .pkt_port        (port_ff),
      .stored_port     (port_q),
      .result          (mres)
   );

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      r_in           = r_ff;
      j_in           = j_ff;
      base_in        = base_ff;
      lim_in         = lim_ff;
      idx_in         = idx_ff;
      dir_in         = dir_ff;
      addr_in        = addr_ff;
      port_in        = port_ff;
      est_in         = est_ff;
      res_verdict_in = res_verdict_ff;
      res_matched_in = res_matched_ff;
      res_tag_in     = res_tag_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_status_in  = rsp_status_ff;

      case (state_ff)
         ST_CLEAR: begin
            clr_in = RW'(clr_ff + RW'(1));
            if (clr_ff == RW'(RULE_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            j_in = '0;
            if (accept) begin
               idx_in         = req_rule_index;
               dir_in         = req_direction;
               addr_in        = req_address;
               port_in        = req_port_number;
               est_in         = req_established;
               res_verdict_in = VERDICT_ACCEPT;
               res_matched_in = 1'b0;
               res_tag_in     = '0;
               res_status_in  = 1'b0;
               r_in           = '0;
               base_in        = '0;
               lim_in         = (int'(active_ff) > RULE_SLOTS) ?
                                ACTIVE_W'(RULE_SLOTS) : active_ff;
               state_in       = ST_EMIT;
               if ((req_mode == MODE_APPEND) && req_idx_ok) begin
                  state_in = ST_APP_RD;
               end else if (req_mode == MODE_CLASSIFY) begin
                  res_verdict_in = VERDICT_DROP;
                  if (lim_in != '0) begin
                     state_in = ST_CL_HDR;
                  end
               end
            end
         end
         ST_APP_RD: begin
            state_in = ST_APP_WR;
         end
         ST_APP_WR: begin
            res_status_in = idx_ok && (fill_q >= FW'(PORTS_PER_RULE));
            state_in      = ST_EMIT;
         end
         ST_CL_HDR: begin
            j_in     = '0;
            state_in = ST_CL_EVL;
         end
         ST_CL_EVL: begin
            if (mres.hdr_hit && (mres.any_port || ((j_ff < fill_q) && mres.port_hit))) begin
               res_verdict_in = hdr_q.action;
               res_matched_in = 1'b1;
               res_tag_in     = hdr_q.tag;
               state_in       = ST_EMIT;
            end else if (mres.hdr_hit && (j_ff < fill_q)) begin
               j_in = FW'(j_ff + FW'(1));
            end else begin
               j_in = '0;
               if (last_rule) begin
                  state_in = ST_EMIT;
               end else begin
                  r_in     = RW'(r_ff + RW'(1));
                  base_in  = PW'(base_ff + PW'(PORTS_PER_RULE));
                  state_in = ST_CL_HDR;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = res_verdict_ff;
               rsp_matched_in = res_matched_ff;
               rsp_tag_in     = res_tag_ff;
               rsp_status_in  = res_status_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         r_ff         <= '0;
         j_ff         <= '0;
         base_ff      <= '0;
         lim_ff       <= '0;
         active_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         r_ff         <= r_in;
         j_ff         <= j_in;
         base_ff      <= base_in;
         lim_ff       <= lim_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      dir_ff         <= dir_in;
      addr_ff        <= addr_in;
      port_ff        <= port_in;
      est_ff         <= est_in;
      res_verdict_ff <= res_verdict_in;
      res_matched_ff <= res_matched_in;
      res_tag_ff     <= res_tag_in;
      res_status_ff  <= res_status_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = rsp_verdict_ff;
   assign rsp_matched     = rsp_matched_ff;
   assign rsp_matched_tag = rsp_tag_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

// File: tb/filter_check_pkg.sv
`timescale 1ns / 100ps
// Beat types and the result scoreboard for the first-match packet filter bench.
// Depends on fmpf_pkg for field widths, mode codes and verdict codes.
package filter_check_pkg;
   import fmpf_pkg::*;

   localparam int RULE_COUNT   = 64;
   localparam int PORT_SLOTS   = 8;
   localparam int REPORT_LIMIT = 10;

   localparam logic [MODE_W-1:0]   MODE_IGNORED  = 2'd3;
   localparam logic [ACTION_W-1:0] ACTION_UNUSED = 2'd3;

   typedef struct {
      logic [MODE_W-1:0]   mode;
      logic [INDEX_W-1:0]  rule_index;
      logic                direction;
      logic [ACTION_W-1:0] action_code;
      logic [ADDR_W-1:0]   address;
      logic [PREFIX_W-1:0] prefix_len;
      logic                any_address;
      logic                any_port;
      logic                needs_established;
      logic [TAG_W-1:0]    rule_tag;
      logic [PORT_W-1:0]   port_number;
      logic                established;
   } filter_req_type;

   typedef struct {
      logic [ACTION_W-1:0] verdict;
      logic                matched;
      logic [TAG_W-1:0]    matched_tag;
      logic                status;
   } filter_rsp_type;

   class filter_scoreboard;
      rule_hdr_type      hdr[RULE_COUNT];
      logic [PORT_W-1:0] port_list[RULE_COUNT][PORT_SLOTS];
      int unsigned       fill[RULE_COUNT];
      int unsigned       active_rules;
      filter_rsp_type    pending_verdicts[$];
      int                failures;

      function new();
         foreach (fill[i]) begin
            fill[i] = 0;
            hdr[i]  = '0;
         end
         active_rules = 0;
         failures     = 0;
      endfunction

      function int unsigned searched_rules();
         return (active_rules > RULE_COUNT) ? RULE_COUNT : active_rules;
      endfunction

      function int outstanding();
         return pending_verdicts.size();
      endfunction

      function void report(string what);
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("%0t mismatch: %s", $time, what);
         end
      endfunction

      function bit rule_hits(int r, filter_req_type p);
         logic [ADDR_W-1:0] mask;
         bit                port_ok;
         int unsigned       j;
         if (hdr[r].dir != p.direction) begin
            return 0;
         end
         mask = 32'hFFFF_FFFF << (32 - hdr[r].prefix);
         if (!hdr[r].any_address && ((p.address ^ hdr[r].network) & mask) != '0) begin
            return 0;
         end
         if (!hdr[r].any_port) begin
            port_ok = 0;
            for (j = 0; j < fill[r]; j++) begin
               if (port_list[r][j] == p.port_number) begin
                  port_ok = 1;
               end
            end
            if (!port_ok) begin
               return 0;
            end
         end
         if (hdr[r].needs_est && !p.established) begin
            return 0;
         end
         return 1;
      endfunction

      function void note_request(filter_req_type b);
         filter_rsp_type res;
         rule_hdr_type   h;
         int unsigned    r;
         res.verdict     = '0;
         res.matched     = 1'b0;
         res.matched_tag = '0;
         res.status      = 1'b0;
         case (b.mode)
            MODE_LOAD: begin
               h.dir         = b.direction;
               h.action      = (b.action_code == ACTION_UNUSED) ? VERDICT_DROP : b.action_code;
               h.network     = b.address;
               h.prefix      = (b.prefix_len > PREFIX_MAX) ? PREFIX_MAX : b.prefix_len;
               h.any_address = b.any_address;
               h.any_port    = b.any_port;
               h.needs_est   = b.needs_established;
               h.tag         = b.rule_tag;
               hdr[b.rule_index]  = h;
               fill[b.rule_index] = 0;
            end
            MODE_APPEND: begin
               if (fill[b.rule_index] >= PORT_SLOTS) begin
                  res.status = 1'b1;
               end else begin
                  port_list[b.rule_index][fill[b.rule_index]] = b.port_number;
                  fill[b.rule_index]++;
               end
            end
            MODE_CLASSIFY: begin
               res.verdict = VERDICT_DROP;
               for (r = 0; r < searched_rules(); r++) begin
                  if (rule_hits(r, b)) begin
                     res.verdict     = hdr[r].action;
                     res.matched     = 1'b1;
                     res.matched_tag = hdr[r].tag;
                     break;
                  end
               end
            end
            default: begin
            end
         endcase
         pending_verdicts.push_back(res);
      endfunction

      function void check_response(filter_rsp_type got);
         filter_rsp_type want;
         if (pending_verdicts.size() == 0) begin
            report($sformatf("unexpected beat verdict=%0d matched=%0d tag=%h status=%0d",
                             got.verdict, got.matched, got.matched_tag, got.status));
            return;
         end
         want = pending_verdicts.pop_front();
         if (got.verdict !== want.verdict || got.matched !== want.matched ||
             got.matched_tag !== want.matched_tag || got.status !== want.status) begin
            report($sformatf({"expected verdict=%0d matched=%0d tag=%h status=%0d, ",
                              "got verdict=%0d matched=%0d tag=%h status=%0d"},
                             want.verdict, want.matched, want.matched_tag, want.status,
                             got.verdict, got.matched, got.matched_tag, got.status));
         end
      endfunction

      function void close_out();
         if (pending_verdicts.size() != 0) begin
            report($sformatf("%0d results never arrived", pending_verdicts.size()));
         end
      endfunction
   endclass

endpackage

// File: tb/first_match_packet_filter_tb.sv
`timescale 1ns / 100ps
// Top of the first-match packet filter bench: clock, reset, beat drivers and watchdog.
// Depends on fmpf_pkg, filter_check_pkg and the first_match_packet_filter RTL.
module first_match_packet_filter_tb;
   import fmpf_pkg::*;
   import filter_check_pkg::*;

   localparam int ITEM_TARGET     = 1040;
   localparam int IDLE_LIMIT      = 20000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 700;
   localparam int HOLD_OFF_AT     = 100;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam logic [CSR_AW-1:0] ACTIVE_RULES_ADDR = CSR_AW'(4 * CSR_ACTIVE_RULES);

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode;
   logic [INDEX_W-1:0]  req_rule_index;
   logic                req_direction;
   logic [ACTION_W-1:0] req_action_code;
   logic [ADDR_W-1:0]   req_address;
   logic [PREFIX_W-1:0] req_prefix_len;
   logic                req_any_address;
   logic                req_any_port;
   logic                req_needs_established;
   logic [TAG_W-1:0]    req_rule_tag;
   logic [PORT_W-1:0]   req_port_number;
   logic                req_established;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [ACTION_W-1:0] rsp_verdict;
   logic                rsp_matched;
   logic [TAG_W-1:0]    rsp_matched_tag;
   logic                rsp_status;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   filter_scoreboard sb = new();
   int               sent = 0;
   int               req_calm = 0;
   int               rsp_calm = 0;
   int               idle_cycles = 0;

   first_match_packet_filter #(
      .RULE_SLOTS     (RULE_COUNT),
      .PORTS_PER_RULE (PORT_SLOTS)
   ) dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_mode              (req_mode),
      .req_rule_index        (req_rule_index),
      .req_direction         (req_direction),
      .req_action_code       (req_action_code),
      .req_address           (req_address),
      .req_prefix_len        (req_prefix_len),
      .req_any_address       (req_any_address),
      .req_any_port          (req_any_port),
      .req_needs_established (req_needs_established),
      .req_rule_tag          (req_rule_tag),
      .req_port_number       (req_port_number),
      .req_established       (req_established),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_verdict           (rsp_verdict),
      .rsp_matched           (rsp_matched),
      .rsp_matched_tag       (rsp_matched_tag),
      .rsp_status            (rsp_status),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("first_match_packet_filter_tb NOT OK");
         $finish;
      end
   end

   function automatic int pick_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(10, 40);
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic filter_req_type make_beat(input logic [MODE_W-1:0] mode);
      filter_req_type b;
      b.mode              = mode;
      b.rule_index        = INDEX_W'($urandom);
      b.direction         = 1'($urandom);
      b.action_code       = ACTION_W'($urandom);
      b.address           = $urandom;
      b.prefix_len        = PREFIX_W'($urandom);
      b.any_address       = 1'($urandom);
      b.any_port          = 1'($urandom);
      b.needs_established = 1'($urandom);
      b.rule_tag          = TAG_W'($urandom);
      b.port_number       = PORT_W'($urandom);
      b.established       = 1'($urandom);
      return b;
   endfunction

   task automatic send_beat(input filter_req_type b);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_mode              <= b.mode;
      req_rule_index        <= b.rule_index;
      req_direction         <= b.direction;
      req_action_code       <= b.action_code;
      req_address           <= b.address;
      req_prefix_len        <= b.prefix_len;
      req_any_address       <= b.any_address;
      req_any_port          <= b.any_port;
      req_needs_established <= b.needs_established;
      req_rule_tag          <= b.rule_tag;
      req_port_number       <= b.port_number;
      req_established       <= b.established;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_request(b);
      sent++;
   endtask

   task automatic load_rule(input logic [INDEX_W-1:0] idx, input logic dir,
                            input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
                            input logic [PREFIX_W-1:0] plen, input logic anya,
                            input logic anyp, input logic need, input logic [TAG_W-1:0] tag);
      filter_req_type b;
      b = make_beat(MODE_LOAD);
      b.rule_index        = idx;
      b.direction         = dir;
      b.action_code       = act;
      b.address           = addr;
      b.prefix_len        = plen;
      b.any_address       = anya;
      b.any_port          = anyp;
      b.needs_established = need;
      b.rule_tag          = tag;
      send_beat(b);
   endtask

   task automatic append_port(input logic [INDEX_W-1:0] idx, input logic [PORT_W-1:0] pkt_port);
      filter_req_type b;
      b = make_beat(MODE_APPEND);
      b.rule_index  = idx;
      b.port_number = pkt_port;
      send_beat(b);
   endtask

   task automatic classify(input logic dir, input logic [ADDR_W-1:0] addr,
                           input logic [PORT_W-1:0] pkt_port, input logic est);
      filter_req_type b;
      b = make_beat(MODE_CLASSIFY);
      b.direction   = dir;
      b.address     = addr;
      b.port_number = pkt_port;
      b.established = est;
      send_beat(b);
   endtask

   task automatic load_random_rule(input int idx);
      int                  n;
      logic [PREFIX_W-1:0] plen;
      plen = ($urandom_range(0, 3) == 0) ? PREFIX_W'($urandom_range(33, 63))
                                         : PREFIX_W'($urandom_range(0, 32));
      load_rule(INDEX_W'(idx), 1'($urandom), ACTION_W'($urandom), $urandom, plen,
                $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
                $urandom_range(0, 2) == 0, TAG_W'($urandom));
      case ($urandom_range(0, 9))
         0: n = 0;
         9: n = $urandom_range(PORT_SLOTS, PORT_SLOTS + 2);
         default: n = $urandom_range(1, 4);
      endcase
      repeat (n) append_port(INDEX_W'(idx), PORT_W'($urandom));
   endtask

   // Aims a packet at a random rule in the searched range so that deep rules get hit.
   task automatic classify_targeted();
      int unsigned       span;
      int                r;
      rule_hdr_type      h;
      logic [ADDR_W-1:0] mask;
      logic [PORT_W-1:0] pkt_port;
      span = sb.searched_rules();
      if (span == 0) begin
         classify(1'($urandom), $urandom, PORT_W'($urandom), 1'($urandom));
         return;
      end
      r        = $urandom_range(0, span - 1);
      h        = sb.hdr[r];
      mask     = 32'hFFFF_FFFF << (32 - h.prefix);
      pkt_port = PORT_W'($urandom);
      if (!h.any_port && sb.fill[r] > 0) begin
         pkt_port = sb.port_list[r][$urandom_range(0, sb.fill[r] - 1)];
      end
      classify(h.dir, (h.network & mask) | ($urandom & ~mask), pkt_port,
               h.needs_est ? 1'b1 : 1'($urandom));
   endtask

   task automatic set_active_rules(input int unsigned count);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ACTIVE_RULES_ADDR;
      csr_pwdata  <= CSR_DW'(count);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.active_rules = count & 32'h7F;
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic int unsigned pick_active();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return 1;
         2: return RULE_COUNT;
         3: return 127;
         4: return $urandom_range(RULE_COUNT + 1, 127);
         5, 6: return $urandom_range(13, RULE_COUNT);
         default: return $urandom_range(2, 12);
      endcase
   endfunction

   initial begin
      int got_count;
      filter_rsp_type got;
      int gap;
      got_count = 0;
      rsp_stall <= 1'b1;
      do @(posedge clock); while (reset);
      forever begin
         gap = (got_count == HOLD_OFF_AT) ? HOLD_OFF_CYCLES : pick_gap(rsp_calm);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         got.verdict     = rsp_verdict;
         got.matched     = rsp_matched;
         got.matched_tag = rsp_matched_tag;
         got.status      = rsp_status;
         sb.check_response(got);
         got_count++;
      end
   end

   initial begin
      int i;
      int phase_len;
      reset                 <= 1'b1;
      req_valid             <= 1'b0;
      req_mode              <= MODE_LOAD;
      req_rule_index        <= '0;
      req_direction         <= 1'b0;
      req_action_code       <= VERDICT_ACCEPT;
      req_address           <= '0;
      req_prefix_len        <= '0;
      req_any_address       <= 1'b0;
      req_any_port          <= 1'b0;
      req_needs_established <= 1'b0;
      req_rule_tag          <= '0;
      req_port_number       <= '0;
      req_established       <= 1'b0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      set_active_rules(0);
      classify(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      send_beat(make_beat(MODE_IGNORED));
      load_rule(INDEX_W'(0), 1'b0, ACTION_UNUSED, 32'hFFFF_FFFF, 6'd63, 1'b0, 1'b0, 1'b0,
                16'hFFFF);
      load_rule(INDEX_W'(1), 1'b1, VERDICT_ACCEPT, 32'h0A00_0000, 6'd8, 1'b0, 1'b0, 1'b1,
                16'h0001);
      append_port(INDEX_W'(1), 16'hFFFF);
      append_port(INDEX_W'(1), 16'h0000);
      load_rule(INDEX_W'(2), 1'b0, VERDICT_REJECT, 32'h0000_0000, 6'd0, 1'b1, 1'b1, 1'b1,
                16'h8000);
      load_rule(INDEX_W'(3), 1'b1, VERDICT_DROP, 32'hFFFF_FFFF, 6'd0, 1'b0, 1'b1, 1'b0,
                16'h1234);
      load_rule(INDEX_W'(4), 1'b0, VERDICT_ACCEPT, 32'hC0A8_0001, 6'd32, 1'b0, 1'b0, 1'b0,
                16'h0044);
      for (i = 0; i <= PORT_SLOTS; i++) begin
         append_port(INDEX_W'(4), PORT_W'(1000 + i));
      end
      quiesce();
      set_active_rules(5);
      classify(1'b0, 32'hC0A8_0001, 16'd1002, 1'b0);
      classify(1'b0, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
      classify(1'b1, 32'h0A12_3456, 16'hFFFF, 1'b1);
      classify(1'b1, 32'h0A12_3456, 16'h0000, 1'b0);
      classify(1'b0, 32'hC0A8_0002, 16'd1000, 1'b0);
      load_rule(INDEX_W'(1), 1'b1, VERDICT_ACCEPT, 32'h0A00_0000, 6'd8, 1'b0, 1'b0, 1'b1,
                16'h0001);
      classify(1'b1, 32'h0A12_3456, 16'hFFFF, 1'b1);

      // Every slot gets loaded before any setting that searches past the first five.
      for (i = 0; i < RULE_COUNT; i++) begin
         load_random_rule(i);
         if ($urandom_range(0, 3) == 0) begin
            classify_targeted();
         end
      end

      while (sent < ITEM_TARGET) begin
         quiesce();
         set_active_rules(pick_active());
         phase_len = $urandom_range(15, 50);
         repeat (phase_len) begin
            case ($urandom_range(0, 19))
               0, 1, 2: load_random_rule($urandom_range(0, RULE_COUNT - 1));
               3: send_beat(make_beat(MODE_IGNORED));
               4, 5: send_beat(make_beat(MODE_W'($urandom_range(0, 3))));
               default: classify_targeted();
            endcase
         end
      end

      quiesce();
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.close_out();
      if (sb.failures == 0) begin
         $display("first_match_packet_filter_tb OK");
      end else begin
         $display("first_match_packet_filter_tb NOT OK");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/fmpf_pkg.sv
rtl/fmpf_ram.sv
rtl/fmpf_match.sv
rtl/first_match_packet_filter.sv
tb/filter_check_pkg.sv
tb/first_match_packet_filter_tb.sv
